/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, disabled during reset.
`define CSRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `CSRQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* src/csrq_pkg.sv */
`default_nettype none

package csrq_pkg;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned CFG_DW  = 11;
  localparam int unsigned CFG_IW  = 1;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [CFG_IW-1:0] REG_SHIFT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_CAP   = 1'b1;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd3;
  localparam logic [CAP_W-1:0]   CAP_RST   = 11'd1024;

  localparam logic [CHAR_W-1:0] CHR_DASH  = 7'd45;
  localparam logic [7:0]        CHR_A     = 8'd97;
  localparam logic [7:0]        CHR_Z     = 8'd122;
  localparam logic [7:0]        ALPHA_LEN = 8'd26;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [CAP_W-1:0]   cap;
    logic [CAP_W-1:0]   cap_nxt;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CHAR_W-1:0] char_in;
  } op_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              pop_done;
    logic              push_dropped;
    logic              is_empty;
    logic              is_full;
    logic [CAP_W-1:0]  fill_level;
    logic [CHAR_W-1:0] front_stored;
    logic [CHAR_W-1:0] back_stored;
  } res_t;

  function automatic logic [CHAR_W-1:0] csrq_encrypt(input logic [CHAR_W-1:0] ch,
                                                     input logic [SHIFT_W-1:0] sh);
    logic [7:0] s;
    s = {1'b0, ch} + {3'b000, sh};
    if (s > CHR_Z) begin
      s = s - ALPHA_LEN;
    end
    return s[CHAR_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] csrq_decrypt(input logic [CHAR_W-1:0] st,
                                                     input logic [SHIFT_W-1:0] sh);
    logic [7:0] lim;
    logic [7:0] r;
    lim = CHR_A + {3'b000, sh};
    if ({1'b0, st} < lim) begin
      r = {1'b0, st} + ALPHA_LEN - {3'b000, sh};
    end else begin
      r = {1'b0, st} - {3'b000, sh};
    end
    return r[CHAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/csrq_if.sv */
`default_nettype none

interface csrq_in_if import csrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink (input valid, input action, input char_in, output ready);
endinterface

interface csrq_out_if import csrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              pop_done;
  logic              push_dropped;
  logic              is_empty;
  logic              is_full;
  logic [CAP_W-1:0]  fill_level;
  logic [CHAR_W-1:0] front_stored;
  logic [CHAR_W-1:0] back_stored;

  modport source (output valid, output char_out, output pop_done, output push_dropped,
                  output is_empty, output is_full, output fill_level,
                  output front_stored, output back_stored, input ready);
  modport sink (input valid, input char_out, input pop_done, input push_dropped,
                input is_empty, input is_full, input fill_level,
                input front_stored, input back_stored, output ready);
endinterface

`default_nettype wire

/* src/csrq_ram.sv */
`default_nettype none

module csrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/csrq_cfg.sv */
`default_nettype none

module csrq_cfg import csrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  output cfg_t                   cfg_o
);

  localparam int unsigned DEPTH_CLIP = (QUEUE_DEPTH > 2047) ? 2047 : QUEUE_DEPTH;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH_CLIP);

  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [CAP_W-1:0]   cap_q, cap_d;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CAP_W'(1);
    end else if (c > CAP_MAX) begin
      r = CAP_MAX;
    end
    return r;
  endfunction

  always_comb begin
    shift_d = shift_q;
    cap_d   = cap_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHIFT: shift_d = cfg_data_i[SHIFT_W-1:0];
        REG_CAP:   cap_d   = cfg_data_i[CAP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RST;
      cap_q   <= CAP_RST;
    end else begin
      shift_q <= shift_d;
      cap_q   <= cap_d;
    end
  end

  assign cfg_o.shift   = shift_q;
  assign cfg_o.cap     = eff_cap(cap_q);
  assign cfg_o.cap_nxt = eff_cap(cap_d);

endmodule

`default_nettype wire

/* src/csrq_queue.sv */
`default_nettype none

module csrq_queue import csrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic step_i,
  input  wire op_t  op_i,
  output res_t      res_o
);

`include "assert_macros.svh"

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned AW = (IW + 1 > CAP_W + 1) ? IW + 1 : CAP_W + 1;
  localparam int unsigned DEPTH_CLIP = (QUEUE_DEPTH > 2047) ? 2047 : QUEUE_DEPTH;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH_CLIP);
  localparam int unsigned RST_CAP = (QUEUE_DEPTH < 1024) ? QUEUE_DEPTH : 1024;
  localparam logic [IW-1:0] TAIL_RST = IW'(RST_CAP - 1);

  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CAP_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0] front_q, front_d, back_q, back_d;
  logic              byp_q, byp_d;
  logic [CHAR_W-1:0] byp_data_q;

  logic              we;
  logic [IW-1:0]     raddr;
  logic [CHAR_W-1:0] ram_rdata, nxt;
  logic [CHAR_W-1:0] push_val, pop_val;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [CAP_W-1:0] cap);
    logic [AW-1:0] n;
    n = AW'(idx) + AW'(1);
    return (n >= AW'(cap)) ? '0 : n[IW-1:0];
  endfunction

  // second entry of the queue, read ahead; same-edge writes are bypassed
  csrq_ram #(.WIDTH(CHAR_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_d),
    .wdata_i (push_val),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign nxt      = byp_q ? byp_data_q : ram_rdata;
  assign push_val = csrq_encrypt(op_i.char_in, cfg_i.shift);
  assign pop_val  = csrq_decrypt(front_q, cfg_i.shift);

  // front_q mirrors the slot at the head, back_q the slot at the tail
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    front_d = front_q;
    back_d  = back_q;
    we      = 1'b0;
    res_o.char_out     = CHR_DASH;
    res_o.pop_done     = 1'b0;
    res_o.push_dropped = 1'b0;
    if (step_i) begin
      case (op_i.action)
        ACT_PUSH: begin
          if (count_q >= cfg_i.cap) begin
            res_o.push_dropped = 1'b1;
          end else begin
            tail_d  = adv(tail_q, cfg_i.cap);
            we      = 1'b1;
            count_d = count_q + CAP_W'(1);
            back_d  = push_val;
            if (tail_d == head_q) begin
              front_d = push_val;
            end
          end
        end
        ACT_POP: begin
          if (count_q != '0) begin
            head_d  = adv(head_q, cfg_i.cap);
            count_d = count_q - CAP_W'(1);
            res_o.char_out = pop_val;
            res_o.pop_done = 1'b1;
            front_d = nxt;
          end
        end
        default: ;
      endcase
    end
    raddr = adv(head_d, cfg_i.cap_nxt);
    byp_d = we && (tail_d == raddr);
    res_o.is_empty     = (count_d == '0);
    res_o.is_full      = (count_d >= cfg_i.cap);
    res_o.fill_level   = count_d;
    res_o.front_stored = (count_d == '0) ? CHR_DASH : front_d;
    res_o.back_stored  = (count_d == '0) ? CHR_DASH : back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= TAIL_RST;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q    <= front_d;
    back_q     <= back_d;
    byp_data_q <= push_val;
  end

  `CSRQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CAP_MAX, "queue level exceeds depth")
  `CSRQ_ASSERT_NEXT(a_pop_level, clk_i, rst_ni, step_i && op_i.action == ACT_POP && count_q != '0, count_q == $past(count_q) - CAP_W'(1), "pop did not lower level")
  `CSRQ_ASSERT_NEXT(a_push_back, clk_i, rst_ni, step_i && op_i.action == ACT_PUSH && count_q < cfg_i.cap, back_q == $past(push_val), "tail not updated on push")

endmodule

`default_nettype wire

/* src/caesar_shift_ring_queue_unit.sv */
// Input and result registers decouple both sides; one transaction per cycle while out_o
// is not stalled, each stepped from the input register into the result register.
// Queue storage is one RAM read ahead at the slot after the head, with write bypass.
// Reset (rst_ni, async, active low) clears pointers, level, valids and config to defaults.
// Slot contents are undefined after reset; no clearing pass is needed.
`default_nettype none

module caesar_shift_ring_queue_unit import csrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  csrq_in_if.sink                in_i,
  csrq_out_if.source             out_o
);

  cfg_t cfg;
  res_t res, res_q;
  op_t  op_q;
  logic in_vld_q, out_vld_q;
  logic step;

  csrq_cfg #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  csrq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .op_i   (op_q),
    .res_o  (res)
  );

  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q.action  <= in_i.action;
      op_q.char_in <= in_i.char_in;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.char_out     = res_q.char_out;
  assign out_o.pop_done     = res_q.pop_done;
  assign out_o.push_dropped = res_q.push_dropped;
  assign out_o.is_empty     = res_q.is_empty;
  assign out_o.is_full      = res_q.is_full;
  assign out_o.fill_level   = res_q.fill_level;
  assign out_o.front_stored = res_q.front_stored;
  assign out_o.back_stored  = res_q.back_stored;

endmodule

`default_nettype wire

/* tb/caesar_shift_ring_queue_unit_test.sv */
module caesar_shift_ring_queue_unit_test;
  import csrq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam res_t IDLE_RES = '{CHR_DASH, 1'b0, 1'b0, 1'b1, 1'b0, 11'd0, CHR_DASH, CHR_DASH};

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  typedef struct {
    bit                is_cfg;
    logic [ACT_W-1:0]  action;
    logic [CFG_IW-1:0] reg_idx;
    logic [CFG_DW-1:0] value;
    bit                pinned;
    res_t              want;
  } script_row_t;

  // Pinned rows follow directly from reset, the capacity extremes and full/drop behavior.
  script_row_t script [26] = '{
    '{1'b0, ACT_QUERY, REG_SHIFT, 11'd0, 1'b1, IDLE_RES},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b1, IDLE_RES},
    '{1'b0, ACT_SPARE, REG_SHIFT, 11'd0, 1'b1, IDLE_RES},
    '{1'b1, ACT_QUERY, REG_CAP, 11'd0, 1'b0, '0},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd97, 1'b1,
      '{CHR_DASH, 1'b0, 1'b0, 1'b0, 1'b1, 11'd1, 7'd100, 7'd100}},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd122, 1'b1,
      '{CHR_DASH, 1'b0, 1'b1, 1'b0, 1'b1, 11'd1, 7'd100, 7'd100}},
    '{1'b1, ACT_QUERY, REG_CAP, 11'd2047, 1'b0, '0},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd122, 1'b1,
      '{CHR_DASH, 1'b0, 1'b0, 1'b0, 1'b0, 11'd2, 7'd100, 7'd99}},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b1,
      '{7'd97, 1'b1, 1'b0, 1'b0, 1'b0, 11'd1, 7'd99, 7'd99}},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b1,
      '{7'd122, 1'b1, 1'b0, 1'b1, 1'b0, 11'd0, CHR_DASH, CHR_DASH}},
    '{1'b1, ACT_QUERY, REG_SHIFT, 11'd0, 1'b0, '0},
    '{1'b1, ACT_QUERY, REG_CAP, 11'd3, 1'b0, '0},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd127, 1'b1,
      '{CHR_DASH, 1'b0, 1'b0, 1'b0, 1'b0, 11'd1, 7'd101, 7'd101}},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd0, 1'b1,
      '{CHR_DASH, 1'b0, 1'b0, 1'b0, 1'b0, 11'd2, 7'd101, 7'd0}},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd109, 1'b1,
      '{CHR_DASH, 1'b0, 1'b0, 1'b0, 1'b1, 11'd3, 7'd101, 7'd109}},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd98, 1'b1,
      '{CHR_DASH, 1'b0, 1'b1, 1'b0, 1'b1, 11'd3, 7'd101, 7'd109}},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b1,
      '{7'd101, 1'b1, 1'b0, 1'b0, 1'b0, 11'd2, 7'd0, 7'd109}},
    '{1'b1, ACT_QUERY, REG_SHIFT, 11'h7FF, 1'b0, '0},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b0, '0},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd127, 1'b0, '0},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b0, '0},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b0, '0},
    '{1'b0, ACT_QUERY, REG_SHIFT, 11'd0, 1'b0, '0},
    '{1'b1, ACT_QUERY, REG_SHIFT, 11'd25, 1'b0, '0},
    '{1'b0, ACT_PUSH, REG_SHIFT, 11'd97, 1'b0, '0},
    '{1'b0, ACT_POP, REG_SHIFT, 11'd0, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  csrq_in_if  in_if ();
  csrq_out_if out_if ();

  caesar_shift_ring_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // shadow queue state
  logic [CHAR_W-1:0]  ring_mem [DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_tail;
  int unsigned        ring_level;
  logic [SHIFT_W-1:0] cipher_shift;
  logic [CAP_W-1:0]   cap_raw;

  res_t status_backlog [$];
  int   mismatches = 0;
  int   hold_asks = 0;
  int   burst_left = 0;
  bit   gapless = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned cap_eff(logic [CAP_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    if (raw > DEPTH) begin
      return DEPTH;
    end
    return raw;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx, int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  // A new capacity must leave the live entries where the ring will look for them.
  function automatic bit cap_change_ok(int unsigned n);
    if (n == cap_eff(cap_raw)) begin
      return 1'b1;
    end
    if (ring_level == 0) begin
      return ring_head < n && ring_next(ring_tail, n) == ring_head;
    end
    return ring_head <= ring_tail && ring_tail < n;
  endfunction

  task automatic cipher_ring_step(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                                  output res_t r);
    int unsigned cap;
    int unsigned sum;
    int unsigned s;
    cap = cap_eff(cap_raw);
    r = '0;
    r.char_out = CHR_DASH;
    if (act == ACT_PUSH) begin
      if (ring_level >= cap) begin
        r.push_dropped = 1'b1;
      end else begin
        sum = ch + cipher_shift;
        if (sum > CHR_Z) begin
          sum = sum - ALPHA_LEN;
        end
        ring_tail = ring_next(ring_tail, cap);
        ring_mem[ring_tail] = CHAR_W'(sum);
        ring_level++;
      end
    end else if (act == ACT_POP) begin
      if (ring_level != 0) begin
        s = ring_mem[ring_head];
        ring_head = ring_next(ring_head, cap);
        ring_level--;
        if (s < CHR_A + cipher_shift) begin
          r.char_out = CHAR_W'(s + ALPHA_LEN - cipher_shift);
        end else begin
          r.char_out = CHAR_W'(s - cipher_shift);
        end
        r.pop_done = 1'b1;
      end
    end
    r.is_empty = (ring_level == 0);
    r.is_full = (ring_level >= cap);
    r.fill_level = CAP_W'(ring_level);
    r.front_stored = (ring_level == 0) ? CHR_DASH : ring_mem[ring_head];
    r.back_stored = (ring_level == 0) ? CHR_DASH : ring_mem[ring_tail];
  endtask

  task automatic send_op(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                         input bit pinned, input res_t pinned_res);
    int unsigned gap;
    res_t        r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gapless || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.char_in <= ch;
    do @(posedge clk); while (!in_if.ready);
    cipher_ring_step(act, ch, r);
    status_backlog.push_back(pinned ? pinned_res : r);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (status_backlog.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SHIFT) begin
      cipher_shift = value[SHIFT_W-1:0];
    end else begin
      cap_raw = value[CAP_W-1:0];
    end
  endtask

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(97, 122));
  endfunction

  task automatic check_field(input string name, input logic [CAP_W-1:0] want,
                             input logic [CAP_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (status_backlog.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none actual fill %0d",
                 $time, out_if.fill_level);
        mismatches++;
      end else begin
        want = status_backlog.pop_front();
        check_field("char_out", want.char_out, out_if.char_out);
        check_field("pop_done", want.pop_done, out_if.pop_done);
        check_field("push_dropped", want.push_dropped, out_if.push_dropped);
        check_field("is_empty", want.is_empty, out_if.is_empty);
        check_field("is_full", want.is_full, out_if.is_full);
        check_field("fill_level", want.fill_level, out_if.fill_level);
        check_field("front_stored", want.front_stored, out_if.front_stored);
        check_field("back_stored", want.back_stored, out_if.back_stored);
      end
    end
  end

  initial begin
    rx_mode_e    mode;
    int unsigned seg;
    int unsigned k;
    int          holds_served;
    logic [7:0]  stall_pattern;
    out_if.ready <= 1'b0;
    holds_served = 0;
    k = 0;
    forever begin
      seg = $urandom_range(16, 160);
      mode = rx_mode_e'($urandom_range(0, 3));
      stall_pattern = 8'($urandom_range(1, 255));
      repeat (seg) begin
        if (hold_asks != holds_served) begin
          holds_served++;
          out_if.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          RX_ALWAYS: begin
            out_if.ready <= 1'b1;
          end
          RX_COIN: begin
            out_if.ready <= 1'($urandom_range(0, 1));
          end
          RX_PATTERN: begin
            out_if.ready <= stall_pattern[k[2:0]];
          end
          default: begin
            out_if.ready <= ($urandom_range(0, 4) == 0);
          end
        endcase
        k++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned       push_pct;
    int unsigned       pop_pct;
    int unsigned       n_items;
    int unsigned       roll;
    int unsigned       target;
    logic [CFG_DW-1:0] raw;
    logic [ACT_W-1:0]  act;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_QUERY;
    in_if.char_in <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_SHIFT;
    cfg_data <= '0;
    rst_n <= 1'b0;
    cipher_shift = SHIFT_RST;
    cap_raw = CAP_RST;
    ring_head = 0;
    ring_level = 0;
    ring_tail = cap_eff(cap_raw) - 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_op(script[i].action, script[i].value[CHAR_W-1:0], script[i].pinned,
                script[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: raw = CFG_DW'(0);
        1: raw = CFG_DW'(25);
        2: raw = CFG_DW'(31);
        default: raw = CFG_DW'($urandom_range(0, 2047));
      endcase
      settle();
      write_reg(REG_SHIFT, raw);

      if (ph == 0) begin
        raw = $urandom_range(0, 1) ? 11'd1024 : CFG_DW'($urandom_range(1025, 2047));
      end else begin
        case ($urandom_range(0, 7))
          0: raw = CFG_DW'(0);
          1: raw = CFG_DW'(1);
          2: raw = CFG_DW'($urandom_range(1, 1024));
          3: raw = CFG_DW'($urandom_range(1025, 2047));
          default: raw = CFG_DW'($urandom_range(2, 16));
        endcase
      end
      target = cap_eff(raw);
      if (!cap_change_ok(target)) begin
        while (ring_level != 0) begin
          send_op(ACT_POP, rand_char(), 1'b0, '0);
        end
      end
      if (!cap_change_ok(target) && ring_head == 0) begin
        send_op(ACT_PUSH, rand_char(), 1'b0, '0);
      end
      if (!cap_change_ok(target)) begin
        raw = CFG_DW'($urandom_range(ring_head + 1, 2047));
      end
      settle();
      write_reg(REG_CAP, raw);

      gapless = (ph % 3 == 1);
      if (ph == 0) begin
        push_pct = 97;
        pop_pct = 2;
        n_items = 1200;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            push_pct = 45;
            pop_pct = 45;
          end
          1: begin
            push_pct = 70;
            pop_pct = 20;
          end
          default: begin
            push_pct = 20;
            pop_pct = 70;
          end
        endcase
        n_items = $urandom_range(60, 120);
      end
      // receiver backs off while the sender keeps offering, so the input stalls
      if (ph == 1) begin
        hold_asks <= hold_asks + 1;
      end
      repeat (n_items) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          act = ACT_PUSH;
        end else if (roll < push_pct + pop_pct) begin
          act = ACT_POP;
        end else begin
          act = $urandom_range(0, 1) ? ACT_QUERY : ACT_SPARE;
        end
        send_op(act, rand_char(), 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
